FILE: rtl/oaief_pkg.sv
`default_nettype none

package oaief_pkg;

    // field widths of a request and a result
    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 4;
    localparam int ECNT_W  = 5;

    localparam int CAPACITY_DEF = 16;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic        [MODE_W-1:0] mode;
        logic        [POS_W-1:0]  position;
        logic signed [VAL_W-1:0]  value;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [FIDX_W-1:0] found_index;
        logic [ECNT_W-1:0] entry_count;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_DOWN,
        S_DRAIN,
        S_WRVAL,
        S_SCAN,
        S_SCAN_LAST
    } ctrl_state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT_M1,
        IDX_POS_P1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic              load;
        idx_op_t           idx_op;
        logic              rd_up;
        logic              rd_dn;
        logic              rd_scan;
        logic              wr_val;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              res_set;
        logic [STAT_W-1:0] res_status;
        logic              res_found;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              cnt_zero;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              pos_eq_cnt;
        logic              pos_is_last;
        logic              idx_at_pos;
        logic              idx_at_last;
        logic              match;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ordered_array_insert_erase_find.sv
//  channel   ports                      handshake
//  --------  -------------------------  ------------------------------------
//  request   request (request_t)        taken at an edge with start && !busy
//  result    result (result_t), done    valid for the single cycle done is high
//
//  with c entries and position p, busy stays high while the request is worked:
//    insert at p < c: words p..c-1 shift up, one ram read/write per shifted word
//    insert at the end: only the value is written; erase at p < c-1: shift down
//    erase of the last entry, and any rejected request: done in decode
//    find: reads from index 0 to a hit or the last entry, one ram read per entry
//  the result strobe comes in the first cycle busy is low again, when a new
//  request may already be taken; the receiver cannot stall the result.
//  reset clears the entry count, state and strobes; the word store itself is not cleared.
`default_nettype none

module ordered_array_insert_erase_find import oaief_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output result_t       result,
    output logic          done
);

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: decodes the request and steps the shift or scan
    oaief_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath: word ram, entry count, index, pending write and result register
    oaief_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

endmodule

`default_nettype wire

FILE: rtl/oaief_ram.sv
`default_nettype none

module oaief_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/oaief_ctrl.sv
`default_nettype none

module oaief_ctrl import oaief_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output logic          busy,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.full || stat.pos_gt_cnt)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_eq_cnt)
                        begin
                            state_next = S_WRVAL;
                        end
                        else
                        begin
                            state_next = S_UP;
                        end
                    end
                    MODE_ERASE:
                    begin
                        if (stat.pos_ge_cnt || stat.pos_is_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DOWN;
                        end
                    end
                    MODE_FIND:
                    begin
                        if (stat.cnt_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_UP:
            begin
                if (stat.idx_at_pos)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DOWN:
            begin
                if (stat.idx_at_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.mode == MODE_INSERT)
                begin
                    state_next = S_WRVAL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRVAL:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.idx_at_last)
                begin
                    state_next = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.res_status = ST_OK;
        busy           = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_FULL;
                        end
                        else if (stat.pos_gt_cnt)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD;
                        end
                        else if (!stat.pos_eq_cnt)
                        begin
                            cmd.idx_op = IDX_CNT_M1;
                        end
                    end
                    MODE_ERASE:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD;
                        end
                        else if (stat.pos_is_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                            cmd.res_set = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS_P1;
                        end
                    end
                    MODE_FIND:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                        end
                    end
                    default:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_BAD;
                    end
                endcase
            end
            S_UP:
            begin
                cmd.rd_up = 1'b1;
                if (!stat.idx_at_pos)
                begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_DOWN:
            begin
                cmd.rd_dn = 1'b1;
                if (!stat.idx_at_last)
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DRAIN:
            begin
                if (stat.mode != MODE_INSERT)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.res_set = 1'b1;
                end
            end
            S_WRVAL:
            begin
                cmd.wr_val  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.res_set = 1'b1;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    if (!stat.idx_at_last)
                    begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_SCAN_LAST:
            begin
                cmd.res_set   = 1'b1;
                cmd.res_found = stat.match;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/oaief_dp.sv
`default_nettype none

module oaief_dp import oaief_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t request,
    input  wire dp_cmd_t  cmd,
    output dp_stat_t      stat,
    output result_t       result,
    output logic          done
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    request_t         req_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_next;
    logic             pend_valid_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic             chk_valid_reg;
    logic [AW-1:0]    chk_idx_reg;
    result_t          result_reg;
    logic             done_reg;

    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    cnt_x;
    logic [CW-1:0]    cnt_m1;
    logic [AW-1:0]    pos_a;
    logic             rd_en;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [VAL_W-1:0] rdata;

    assign pos_x  = PW'(req_reg.position);
    assign cnt_x  = PW'(count_reg);
    assign cnt_m1 = count_reg - CW'(1);
    assign pos_a  = AW'(req_reg.position);
    assign rd_en  = cmd.rd_up | cmd.rd_dn | cmd.rd_scan;

    // a shifted word is written in the cycle after its read; a new word goes in on its own cycle
    always_comb
    begin
        if (cmd.wr_val)
        begin
            we    = 1'b1;
            waddr = pos_a;
            wdata = req_reg.value;
        end
        else
        begin
            we    = pend_valid_reg;
            waddr = pend_addr_reg;
            wdata = rdata;
        end
    end

    oaief_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = cnt_m1;
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_CNT_M1: idx_next = AW'(cnt_m1);
            IDX_POS_P1: idx_next = pos_a + AW'(1);
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + AW'(1);
            IDX_DEC:    idx_next = idx_reg - AW'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        stat.mode        = req_reg.mode;
        stat.full        = (count_reg == CW'(CAPACITY));
        stat.cnt_zero    = (count_reg == '0);
        stat.pos_gt_cnt  = (pos_x > cnt_x);
        stat.pos_ge_cnt  = (pos_x >= cnt_x);
        stat.pos_eq_cnt  = (pos_x == cnt_x);
        stat.pos_is_last = ((pos_x + PW'(1)) == cnt_x);
        stat.idx_at_pos  = (idx_reg == pos_a);
        stat.idx_at_last = (idx_reg == AW'(cnt_m1));
        stat.match       = chk_valid_reg && (rdata == req_reg.value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= cmd.rd_up | cmd.rd_dn;
            chk_valid_reg  <= cmd.rd_scan;
            done_reg       <= cmd.res_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        idx_reg     <= idx_next;
        chk_idx_reg <= idx_reg;
        if (cmd.rd_up)
        begin
            pend_addr_reg <= idx_reg + AW'(1);
        end
        else if (cmd.rd_dn)
        begin
            pend_addr_reg <= idx_reg - AW'(1);
        end
        if (cmd.res_set)
        begin
            result_reg.status      <= cmd.res_status;
            result_reg.found       <= cmd.res_found;
            result_reg.found_index <= cmd.res_found ? FIDX_W'(chk_idx_reg) : '0;
            result_reg.entry_count <= ECNT_W'(count_next);
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire
